// ----- hw/rtl/bst_pkg.sv -----
package bst_pkg;

    // Fixed field widths of the request and reply channels
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned SEM_INDEX_W = 6;
    localparam int unsigned REQ_W       = 16;
    localparam int unsigned STATUS_W    = 2;

    // Default sizing of the table
    localparam int unsigned NUM_SEMS_DEF    = 64;
    localparam int unsigned QUEUE_DEPTH_DEF = 8;
    localparam int unsigned REQ_BITS_DEF    = 16;

    typedef enum logic [KIND_W-1:0] {
        K_CREATE  = 2'd0,
        K_ACQUIRE = 2'd1,
        K_RELEASE = 2'd2,
        K_DESTROY = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        RS_OK    = 2'd0,
        RS_NOSEM = 2'd1,
        RS_QFULL = 2'd2,
        RS_TFULL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SS_INVALID = 2'd0,
        SS_FREE    = 2'd1,
        SS_HELD    = 2'd2
    } t_sem_st;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_LOOK  = 2'd1,
        ST_FETCH = 2'd2,
        ST_EMIT  = 2'd3
    } t_state;

    typedef struct packed {
        t_kind                  kind;
        logic [SEM_INDEX_W-1:0] sem_index;
        logic [REQ_W-1:0]       requester;
    } t_req;

    typedef struct packed {
        logic [REQ_W-1:0]       dest;
        t_status                status;
        logic [SEM_INDEX_W-1:0] assigned_index;
        logic                   last;
    } t_rsp;

endpackage

// ----- hw/rtl/bst_ifs.sv -----
interface bst_req_if;
    logic          valid;
    logic          ready;
    bst_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bst_rsp_if;
    logic          valid;
    logic          ready;
    bst_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bst_ram.sv -----
module bst_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 64,
    localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; hold the last word while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/binary_semaphore_table_core.sv -----
// Semaphore table with a FIFO wait queue per entry.
// i_req carries one request per transfer (kind, sem_index, requester); o_rsp
// carries the replies (dest, status, assigned_index, last). Both channels
// transfer on a clock edge where valid and ready are high.
// The block works on one request at a time. A request takes two steps:
// the idle step reads the entry record from the record memory, and the look
// step decides, writes the record back and loads the reply register. A
// release that hands the semaphore to a waiter takes two more: the fetch step
// takes the waiter id from the queue memory and loads the grant, and the emit
// step sends the caller's reply after it. A new request is taken only once
// the current one is done, so requests do not overlap.
// An acquire that queues sends no reply at all.
// Reset (synchronous, active low) empties the table: the create counter acts
// as a fill count, so no entry at or above it is ever read as live, and no
// clearing pass is needed. A stalled receiver holds the reply register; the
// core waits with the next reply and takes no new request until its own
// replies are in the reply register.
module binary_semaphore_table_core #(
    parameter int unsigned NumSems    = bst_pkg::NUM_SEMS_DEF,
    parameter int unsigned QueueDepth = bst_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned ReqBits    = bst_pkg::REQ_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bst_req_if.sink          i_req,
    bst_rsp_if.source        o_rsp
);

    localparam int unsigned IW   = bst_pkg::SEM_INDEX_W;
    localparam int unsigned RW   = bst_pkg::REQ_W;
    localparam int unsigned SA   = (NumSems > 1) ? $clog2(NumSems) : 1;
    localparam int unsigned NW   = $clog2(NumSems + 1);
    localparam int unsigned CW   = $clog2(QueueDepth + 1);
    localparam int unsigned HW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned PW   = CW + 1;
    localparam int unsigned SW   = (ReqBits < RW) ? ReqBits : RW;
    localparam int unsigned WD   = NumSems * QueueDepth;
    localparam int unsigned WA   = (WD > 1) ? $clog2(WD) : 1;
    localparam int unsigned CMPW = (NW > IW) ? NW : IW;

    typedef struct packed {
        bst_pkg::t_sem_st st;
        logic [CW-1:0]    cnt;
        logic [HW-1:0]    hd;
    } t_sem_rec;

    localparam int unsigned RECW = $bits(t_sem_rec);

    // Control registers
    bst_pkg::t_state r_state, n_state;
    logic [NW-1:0]   r_next;
    logic            r_out_vld;

    // Payload registers
    bst_pkg::t_kind  r_kind;
    logic [IW-1:0]   r_idx;
    logic [SW-1:0]   r_req;
    bst_pkg::t_rsp   r_fin;
    bst_pkg::t_rsp   r_out;

    // Memory ports
    logic            sem_re;
    logic [SA-1:0]   sem_raddr;
    logic [RECW-1:0] sem_rdata;
    logic            sem_we;
    logic [SA-1:0]   sem_waddr;
    t_sem_rec        sem_wdata;
    t_sem_rec        sem_rd;

    logic            ws_we;
    logic            ws_re;
    logic [WA-1:0]   ws_waddr;
    logic [WA-1:0]   ws_raddr;
    logic [SW-1:0]   ws_rdata;

    // Decision of the look cycle
    logic            c_exists;
    logic            c_tfull;
    logic            c_qfull;
    logic            c_grant;
    logic            c_wr;
    logic            c_ws_wr;
    logic            c_create;
    logic [SA-1:0]   c_waddr;
    t_sem_rec        c_wrec;
    bst_pkg::t_rsp   c_fin;
    logic [PW-1:0]   c_tail_sum;
    logic [HW-1:0]   c_tail;
    logic [HW:0]     c_hd_sum;
    logic [HW-1:0]   c_hd_inc;
    logic [WA-1:0]   c_ws_base;

    // Reply offered to the reply register
    logic            c_rep_vld;
    bst_pkg::t_rsp   c_rep;
    logic            c_take;
    logic            accept;

    bst_ram #(.Width(RECW), .Depth(NumSems)) u_sem_ram (
        .i_clk   (i_clk),
        .i_we    (sem_we),
        .i_waddr (sem_waddr),
        .i_wdata (sem_wdata),
        .i_re    (sem_re),
        .i_raddr (sem_raddr),
        .o_rdata (sem_rdata)
    );

    bst_ram #(.Width(SW), .Depth(WD)) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (ws_we),
        .i_waddr (ws_waddr),
        .i_wdata (r_req),
        .i_re    (ws_re),
        .i_raddr (ws_raddr),
        .o_rdata (ws_rdata)
    );

    assign accept    = i_req.valid && i_req.ready;
    assign sem_re    = accept;
    assign sem_raddr = SA'(i_req.data.sem_index);
    assign sem_rd    = t_sem_rec'(sem_rdata);

    // Queue arithmetic: tail slot and next head, both modulo the queue depth
    assign c_tail_sum = PW'(sem_rd.hd) + PW'(sem_rd.cnt);
    assign c_tail     = (c_tail_sum >= PW'(QueueDepth)) ?
                        HW'(c_tail_sum - PW'(QueueDepth)) : HW'(c_tail_sum);
    assign c_hd_sum   = (HW + 1)'(sem_rd.hd) + (HW + 1)'(1);
    assign c_hd_inc   = (c_hd_sum >= (HW + 1)'(QueueDepth)) ? '0 : HW'(c_hd_sum);
    assign c_ws_base  = WA'(WA'(SA'(r_idx)) * WA'(QueueDepth));

    // An entry is live only below the create counter and not destroyed
    assign c_exists = (CMPW'(r_idx) < CMPW'(r_next)) && (sem_rd.st != bst_pkg::SS_INVALID);
    assign c_tfull  = (r_next == NW'(NumSems));
    assign c_qfull  = (sem_rd.cnt >= CW'(QueueDepth));

    always_comb begin
        c_wr     = 1'b0;
        c_ws_wr  = 1'b0;
        c_grant  = 1'b0;
        c_create = 1'b0;
        c_waddr  = SA'(r_idx);
        c_wrec   = sem_rd;
        c_fin    = '{dest: RW'(r_req), status: bst_pkg::RS_OK,
                     assigned_index: '0, last: 1'b1};
        if (r_kind == bst_pkg::K_CREATE) begin
            if (c_tfull) begin
                c_fin.status = bst_pkg::RS_TFULL;
            end else begin
                c_wr                 = 1'b1;
                c_create             = 1'b1;
                c_waddr              = SA'(r_next);
                c_wrec               = '{st: bst_pkg::SS_FREE, cnt: '0, hd: '0};
                c_fin.assigned_index = IW'(r_next);
            end
        end else if (!c_exists) begin
            c_fin.status = bst_pkg::RS_NOSEM;
        end else begin
            case (r_kind)
                bst_pkg::K_ACQUIRE: begin
                    if (sem_rd.st == bst_pkg::SS_FREE) begin
                        c_wr      = 1'b1;
                        c_wrec.st = bst_pkg::SS_HELD;
                    end else if (c_qfull) begin
                        c_fin.status = bst_pkg::RS_QFULL;
                    end else begin
                        // Append the caller; no reply
                        c_wr       = 1'b1;
                        c_ws_wr    = 1'b1;
                        c_wrec.cnt = sem_rd.cnt + CW'(1);
                    end
                end
                bst_pkg::K_RELEASE: begin
                    if (sem_rd.st == bst_pkg::SS_HELD && sem_rd.cnt != '0) begin
                        // Pop the head waiter; it keeps the semaphore held
                        c_wr       = 1'b1;
                        c_grant    = 1'b1;
                        c_wrec.cnt = sem_rd.cnt - CW'(1);
                        c_wrec.hd  = c_hd_inc;
                    end else begin
                        c_wr      = 1'b1;
                        c_wrec.st = bst_pkg::SS_FREE;
                    end
                end
                bst_pkg::K_DESTROY: begin
                    c_wr   = 1'b1;
                    c_wrec = '{st: bst_pkg::SS_INVALID, cnt: '0, hd: '0};
                end
                default: begin
                    c_wr = 1'b0;
                end
            endcase
        end
    end

    // Write back only in the look cycle; the next record read waits for the return to idle
    assign sem_we    = (r_state == bst_pkg::ST_LOOK) && c_wr;
    assign sem_waddr = c_waddr;
    assign sem_wdata = c_wrec;
    assign ws_we     = (r_state == bst_pkg::ST_LOOK) && c_ws_wr;
    assign ws_waddr  = c_ws_base + WA'(c_tail);
    assign ws_re     = (r_state == bst_pkg::ST_LOOK) && c_grant;
    assign ws_raddr  = c_ws_base + WA'(sem_rd.hd);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bst_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = bst_pkg::ST_LOOK;
                end
            end
            bst_pkg::ST_LOOK: begin
                // A queued acquire has nothing to send; go back for the next request
                if (c_grant) begin
                    n_state = bst_pkg::ST_FETCH;
                end else if (c_ws_wr || c_take) begin
                    n_state = bst_pkg::ST_IDLE;
                end else begin
                    n_state = bst_pkg::ST_EMIT;
                end
            end
            bst_pkg::ST_FETCH: begin
                if (c_take) begin
                    n_state = bst_pkg::ST_EMIT;
                end
            end
            bst_pkg::ST_EMIT: begin
                if (c_take) begin
                    n_state = bst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bst_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: ready and the reply it offers
    always_comb begin
        c_rep_vld   = 1'b0;
        c_rep       = r_fin;
        i_req.ready = 1'b0;
        case (r_state)
            bst_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            bst_pkg::ST_LOOK: begin
                c_rep_vld = !c_grant && !c_ws_wr;
                c_rep     = c_fin;
            end
            bst_pkg::ST_FETCH: begin
                c_rep_vld = 1'b1;
                c_rep     = '{dest: RW'(ws_rdata), status: bst_pkg::RS_OK,
                              assigned_index: '0, last: 1'b0};
            end
            bst_pkg::ST_EMIT: begin
                c_rep_vld = 1'b1;
                c_rep     = r_fin;
            end
            default: begin
                c_rep_vld = 1'b0;
            end
        endcase
    end

    // Reply register takes a reply when empty or being drained
    assign c_take = c_rep_vld && (!r_out_vld || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bst_pkg::ST_IDLE;
            r_next    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bst_pkg::ST_LOOK && c_create) begin
                r_next <= r_next + NW'(1);
            end
            if (c_take) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_req.data.kind;
            r_idx  <= i_req.data.sem_index;
            r_req  <= SW'(i_req.data.requester);
        end
        // Hold the caller's reply while a grant or a stall is pending
        if (r_state == bst_pkg::ST_LOOK) begin
            r_fin <= c_fin;
        end
        if (c_take) begin
            r_out <= c_rep;
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

endmodule

// ----- bench/tb_binary_semaphore_table_core.sv -----
`timescale 1ns / 100ps

module tb_binary_semaphore_table_core;

    localparam int unsigned NUM_SEMS = bst_pkg::NUM_SEMS_DEF;
    localparam int unsigned QDEPTH   = bst_pkg::QUEUE_DEPTH_DEF;

    // Clock and reset: 20 ns period; reset is held low, then released before the first test.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #10 i_clk = ~i_clk;

    bst_req_if req_ch ();
    bst_rsp_if rsp_ch ();

    binary_semaphore_table_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Mirror of the semaphore table. Updated at every request transfer,
    // it yields the replies the core must send, in order.
    // ------------------------------------------------------------------
    bst_pkg::t_sem_st sem_mirror   [NUM_SEMS];
    int unsigned      waiter_count [NUM_SEMS];
    int unsigned      waiter_head  [NUM_SEMS];
    logic [15:0]      waiter_ids   [NUM_SEMS*QDEPTH];
    int unsigned      next_index;

    // Replies still owed by the core, oldest first.
    bst_pkg::t_rsp pending_replies [$];

    int  mismatch_count = 0;
    bit  src_gaps_on    = 1'b0;
    bit  snk_gaps_on    = 1'b0;
    int  hold_off_reqs  = 0;

    function automatic bst_pkg::t_rsp make_reply(logic [15:0] dest, bst_pkg::t_status st,
                                                 logic [5:0] ix, logic lst);
        bst_pkg::t_rsp r;
        r.dest           = dest;
        r.status         = st;
        r.assigned_index = ix;
        r.last           = lst;
        return r;
    endfunction

    // Apply one request to the mirror and queue the replies it causes.
    function automatic void predict_semaphore_op(bst_pkg::t_kind k, logic [5:0] ix,
                                                 logic [15:0] rq);
        int unsigned pos;
        int unsigned h;
        if (k == bst_pkg::K_CREATE) begin
            if (next_index >= NUM_SEMS) begin
                pending_replies.push_back(make_reply(rq, bst_pkg::RS_TFULL, '0, 1'b1));
            end else begin
                sem_mirror[next_index]   = bst_pkg::SS_FREE;
                waiter_count[next_index] = 0;
                waiter_head[next_index]  = 0;
                pending_replies.push_back(
                    make_reply(rq, bst_pkg::RS_OK, 6'(next_index), 1'b1));
                next_index++;
            end
        end else if (ix >= NUM_SEMS || sem_mirror[ix] == bst_pkg::SS_INVALID) begin
            // Nothing changes on a dead or never-created entry.
            pending_replies.push_back(make_reply(rq, bst_pkg::RS_NOSEM, '0, 1'b1));
        end else begin
            case (k)
                bst_pkg::K_ACQUIRE: begin
                    if (sem_mirror[ix] == bst_pkg::SS_FREE) begin
                        sem_mirror[ix] = bst_pkg::SS_HELD;
                        pending_replies.push_back(make_reply(rq, bst_pkg::RS_OK, '0, 1'b1));
                    end else if (waiter_count[ix] >= QDEPTH) begin
                        pending_replies.push_back(
                            make_reply(rq, bst_pkg::RS_QFULL, '0, 1'b1));
                    end else begin
                        // Queue the caller silently; the grant comes on a later release.
                        pos = (waiter_head[ix] + waiter_count[ix]) % QDEPTH;
                        waiter_ids[ix*QDEPTH + pos] = rq;
                        waiter_count[ix]++;
                    end
                end
                bst_pkg::K_RELEASE: begin
                    if (sem_mirror[ix] == bst_pkg::SS_HELD && waiter_count[ix] > 0) begin
                        // Hand over to the oldest waiter: grant first, then the caller.
                        h = waiter_head[ix];
                        pending_replies.push_back(
                            make_reply(waiter_ids[ix*QDEPTH + h], bst_pkg::RS_OK, '0, 1'b0));
                        pending_replies.push_back(make_reply(rq, bst_pkg::RS_OK, '0, 1'b1));
                        waiter_head[ix] = (h + 1) % QDEPTH;
                        waiter_count[ix]--;
                    end else begin
                        sem_mirror[ix] = bst_pkg::SS_FREE;
                        pending_replies.push_back(make_reply(rq, bst_pkg::RS_OK, '0, 1'b1));
                    end
                end
                default: begin
                    // Destroy drops all waiters without a word to them.
                    sem_mirror[ix]   = bst_pkg::SS_INVALID;
                    waiter_count[ix] = 0;
                    waiter_head[ix]  = 0;
                    pending_replies.push_back(make_reply(rq, bst_pkg::RS_OK, '0, 1'b1));
                end
            endcase
        end
    endfunction

    function automatic void log_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Request side. Drive on the rising edge, sample ready right after it
    // (the value the core saw at that edge). Valid stays high between
    // back-to-back transfers; it drops only for an idle burst or a pause.
    // ------------------------------------------------------------------
    task automatic send_request(bst_pkg::t_kind k, logic [5:0] ix, logic [15:0] rq);
        bst_pkg::t_req item;
        if (src_gaps_on && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        item.kind      = k;
        item.sem_index = ix;
        item.requester = rq;
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predict_semaphore_op(k, ix, rq);
    endtask

    // Drop valid and hold until every owed reply has come back or the limit runs out.
    task automatic wait_for_replies(input int limit, output bit drained);
        int waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending_replies.size() != 0 && waited < limit);
        drained = (pending_replies.size() == 0);
    endtask

    function automatic int count_live();
        int n;
        n = 0;
        for (int i = 0; i < next_index; i++)
            if (sem_mirror[i] != bst_pkg::SS_INVALID) n++;
        return n;
    endfunction

    function automatic int pick_live();
        int live [$];
        for (int i = 0; i < next_index; i++)
            if (sem_mirror[i] != bst_pkg::SS_INVALID) live.push_back(i);
        if (live.size() == 0) return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // Mostly well-formed traffic on the live entries, with a little noise.
    task automatic send_random_request();
        int roll;
        int target;
        int live_n;
        logic [15:0] rq;
        roll   = $urandom_range(0, 99);
        live_n = count_live();
        target = pick_live();
        rq     = 16'($urandom_range(0, 65535));
        if (roll < 6) begin
            send_request(bst_pkg::t_kind'($urandom_range(0, 3)),
                         6'($urandom_range(0, 63)), rq);
        end else if (target < 0 || (live_n < 4 && roll < 20)) begin
            send_request(bst_pkg::K_CREATE, 6'($urandom_range(0, 63)), rq);
        end else if (roll < 22) begin
            send_request(bst_pkg::K_DESTROY, 6'(target), rq);
        end else if (roll < 62) begin
            send_request(bst_pkg::K_ACQUIRE, 6'(target), rq);
        end else begin
            send_request(bst_pkg::K_RELEASE, 6'(target), rq);
        end
    endtask

    // ------------------------------------------------------------------
    // Reply side: ready pattern and checking.
    // ------------------------------------------------------------------
    initial begin : drive_reply_ready
        int hold_left;
        int burst_left;
        int hold_seen;
        hold_left  = 0;
        burst_left = 0;
        hold_seen  = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            // A new long hold-off request restarts the count here.
            if (hold_off_reqs != hold_seen) begin
                hold_seen = hold_off_reqs;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                rsp_ch.ready <= 1'b0;
            end else if (snk_gaps_on && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(1, 6) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_replies
        bst_pkg::t_rsp got;
        bst_pkg::t_rsp want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got = rsp_ch.data;
            if (pending_replies.size() == 0) begin
                log_mismatch($sformatf("unexpected reply dest=%h status=%0d idx=%0d last=%b",
                                       got.dest, got.status, got.assigned_index, got.last));
            end else begin
                want = pending_replies.pop_front();
                if (got.dest !== want.dest || got.status !== want.status ||
                    got.assigned_index !== want.assigned_index || got.last !== want.last)
                    log_mismatch($sformatf(
                        "exp dest=%h status=%0d idx=%0d last=%b, got dest=%h status=%0d idx=%0d last=%b",
                        want.dest, want.status, want.assigned_index, want.last,
                        got.dest, got.status, got.assigned_index, got.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Create, grant, queue, hand over, free, invalid entries and destroy.
    task automatic test_basic_ops();
        send_request(bst_pkg::K_CREATE, 6'd0, 16'h0000);
        send_request(bst_pkg::K_CREATE, 6'd63, 16'hFFFF);
        send_request(bst_pkg::K_CREATE, 6'd17, 16'h5A5A);
        send_request(bst_pkg::K_ACQUIRE, 6'd0, 16'h1111);   // free: grant at once
        send_request(bst_pkg::K_ACQUIRE, 6'd0, 16'h2222);   // held: queue silently
        send_request(bst_pkg::K_ACQUIRE, 6'd0, 16'h1111);   // owner asks again: queue
        send_request(bst_pkg::K_RELEASE, 6'd0, 16'h3333);   // non-owner release hands over
        send_request(bst_pkg::K_RELEASE, 6'd0, 16'h2222);
        send_request(bst_pkg::K_RELEASE, 6'd0, 16'h1111);   // empty queue: free the lock
        send_request(bst_pkg::K_RELEASE, 6'd0, 16'hFFFF);   // already free: stays free
        send_request(bst_pkg::K_ACQUIRE, 6'd63, 16'hABCD);  // never created
        send_request(bst_pkg::K_RELEASE, 6'd63, 16'hABCD);
        send_request(bst_pkg::K_DESTROY, 6'd63, 16'hABCD);
        send_request(bst_pkg::K_ACQUIRE, 6'd1, 16'h4444);
        send_request(bst_pkg::K_ACQUIRE, 6'd1, 16'h5555);
        send_request(bst_pkg::K_DESTROY, 6'd1, 16'h6666);   // waiter dropped, no grant
        send_request(bst_pkg::K_ACQUIRE, 6'd1, 16'h7777);
        send_request(bst_pkg::K_RELEASE, 6'd1, 16'h8888);
        send_request(bst_pkg::K_DESTROY, 6'd1, 16'h9999);
    endtask

    // Fill one queue, overflow it once, then drain it through releases.
    task automatic test_queue_limits();
        send_request(bst_pkg::K_ACQUIRE, 6'd2, 16'($urandom_range(0, 65535)));
        repeat (QDEPTH + 1)
            send_request(bst_pkg::K_ACQUIRE, 6'd2, 16'($urandom_range(0, 65535)));
        repeat (QDEPTH + 1)
            send_request(bst_pkg::K_RELEASE, 6'd2, 16'($urandom_range(0, 65535)));
    endtask

    // Stall the receiver for a long stretch while requests keep coming.
    task automatic test_receiver_hold_off();
        hold_off_reqs++;
        repeat (30) send_random_request();
    endtask

    // Stop sending until the core has answered everything.
    task automatic test_sender_pause();
        bit drained;
        repeat (20) send_random_request();
        wait_for_replies(20000, drained);
        if (!drained) log_mismatch("replies still owed after the sender pause");
    endtask

    task automatic test_random_traffic(int n);
        repeat (n) send_random_request();
    endtask

    // Use up the remaining indices, then keep creating into a full table.
    task automatic test_table_exhaustion();
        while (next_index < NUM_SEMS)
            send_request(bst_pkg::K_CREATE, 6'd0, 16'($urandom_range(0, 65535)));
        repeat (3) send_request(bst_pkg::K_CREATE, 6'($urandom_range(0, 63)),
                                16'($urandom_range(0, 65535)));
    endtask

    initial begin : run_tests
        bit drained;
        for (int i = 0; i < NUM_SEMS; i++) begin
            sem_mirror[i]   = bst_pkg::SS_INVALID;
            waiter_count[i] = 0;
            waiter_head[i]  = 0;
        end
        next_index = 0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_queue_limits();
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;
        test_receiver_hold_off();
        test_sender_pause();
        test_random_traffic(1300);
        // Last stretch runs at full rate on both sides.
        src_gaps_on = 1'b0;
        snk_gaps_on = 1'b0;
        test_table_exhaustion();
        test_random_traffic(60);

        wait_for_replies(20000, drained);
        repeat (16) @(posedge i_clk);
        if (pending_replies.size() != 0)
            log_mismatch($sformatf("%0d replies never arrived", pending_replies.size()));
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin : watchdog
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
